// File: rtl/cab64_pkg.sv
// shared types, alphabet table and lookup functions for the custom base64 codec
package cab64_pkg;

   // alphabet size and codes
   localparam int AlphaLen = 92;
   localparam logic [6:0] DecNullValue = 7'd94;
   localparam logic [5:0] SextetMask = 6'h3F;
   localparam logic [7:0] HighPairMask = 8'h30;

   // direction codes
   localparam logic DirEncode = 1'b0;
   localparam logic DirDecode = 1'b1;

   // result queue geometry
   localparam int RspDepth = 4;
   localparam int RspPtrWidth = $clog2(RspDepth);
   localparam int RspCountWidth = $clog2(RspDepth + 1);

   // alphabet, first character in the top byte
   localparam logic [8*AlphaLen-1:0] Alphabet =
      "OPUV01234wxyzABCD9abcdeJKLMNWXYZ `~!@#f5678ghijklmnopquvEFGHIQRST$%^&*()_+-=[]\\{}|;':\",./<>?";

   // input item
   typedef struct packed {
      logic [7:0] data_in;
      logic       last_in;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] data_out;
      logic       last_out;
   } rsp_type;

   // outcome of one codec step
   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
      logic [1:0] phase;
      logic [7:0] held;
   } step_type;

   // sextet to character
   function automatic logic [7:0] enc_char(input logic [5:0] six);
      enc_char = Alphabet[8*(AlphaLen - 1 - int'(six)) +: 8];
   endfunction

   // character to alphabet position, first match wins
   function automatic logic [6:0] dec_value(input logic [7:0] c);
      logic [6:0] v;
      v = 7'd0;
      for (int i = AlphaLen - 1; i >= 0; i--) begin
         if (Alphabet[8*(AlphaLen - 1 - i) +: 8] == c) begin
            v = 7'(i);
         end
      end
      if (c == 8'd0) begin
         v = DecNullValue;
      end
      dec_value = v;
   endfunction

endpackage

// File: rtl/custom_alphabet_base64_codec_top.sv
// top level of the custom-alphabet base64 codec: input register, codec step, result queue
//
// Usage:
//   req channel carries one byte (encode) or one character (decode) per item,
//   with last_in marking the end of a message. rsp channel carries one
//   character or byte per item, last_out marking the final one of a message.
//   csr_wr_en / csr_wr_data set the direction (0 encode, 1 decode); a write
//   also drops any partial group. The user must make a write only while the
//   block is idle; the block itself does not enforce it.
// Path: input register, then result queue; a full queue holds the item back.
// Throughput: one item per cycle while results per item stay at one or fewer
//   (decoding) and the receiver does not stall; encoding gives up to two
//   results per item, so the one-per-cycle result port sets the rate. The
//   four-entry result queue takes a new step when two entries are free.
// Reset: synchronous; clears direction to encode, the group state and the queue.
//   When the receiver stalls, the queue fills and req_stall rises once the
//   input register holds an item that does not fit.
module custom_alphabet_base64_codec_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cab64_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cab64_pkg::rsp_type  rsp_data,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);

   localparam int PtrW = cab64_pkg::RspPtrWidth;
   localparam int CntW = cab64_pkg::RspCountWidth;

   logic                direction_ff;
   logic [1:0]          phase_ff, phase_in;
   logic [7:0]          held_ff, held_in;
   logic                in_valid_ff, in_valid_in;
   cab64_pkg::req_type  in_item_ff;
   cab64_pkg::rsp_type  rsp_mem_ff [cab64_pkg::RspDepth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   cab64_pkg::step_type step;
   logic                room;
   logic                fire;
   logic                req_take;
   logic                rsp_take;
   logic [PtrW-1:0]     wr_ptr_next1;

   // codec step on the registered item
   cab64_step u_step (
      .direction (direction_ff),
      .phase     (phase_ff),
      .held      (held_ff),
      .item      (in_item_ff),
      .step      (step)
   );

   // handshake
   assign room = count_ff <= CntW'(cab64_pkg::RspDepth - 2);
   assign fire = in_valid_ff & room;
   assign req_stall = in_valid_ff & ~room;
   assign req_take = req_valid & ~req_stall;
   assign rsp_valid = count_ff != '0;
   assign rsp_take = rsp_valid & ~rsp_stall;
   assign rsp_data = rsp_mem_ff[rd_ptr_ff];
   assign wr_ptr_next1 = wr_ptr_ff + PtrW'(1);

   // next control state
   always_comb begin
      in_valid_in = req_take | req_stall;
      phase_in = phase_ff;
      held_in = held_ff;
      if (fire) begin
         phase_in = step.phase;
         held_in = step.held;
      end
      if (csr_wr_en) begin
         phase_in = 2'd0;
         held_in = 8'd0;
      end
      wr_ptr_in = wr_ptr_ff + (fire ? PtrW'(step.count) : PtrW'(0));
      rd_ptr_in = rd_ptr_ff + (rsp_take ? PtrW'(1) : PtrW'(0));
      count_in = count_ff + (fire ? CntW'(step.count) : CntW'(0))
                 - (rsp_take ? CntW'(1) : CntW'(0));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= cab64_pkg::DirEncode;
         phase_ff <= 2'd0;
         held_ff <= 8'd0;
         in_valid_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            direction_ff <= csr_wr_data;
         end
         phase_ff <= phase_in;
         held_ff <= held_in;
         in_valid_ff <= in_valid_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
   end

   // result queue writes, up to two entries per step
   always_ff @(posedge clock) begin
      if (fire && step.count != 2'd0) begin
         rsp_mem_ff[wr_ptr_ff] <= step.res0;
      end
      if (fire && step.count == 2'd2) begin
         rsp_mem_ff[wr_ptr_next1] <= step.res1;
      end
   end

endmodule

// File: rtl/cab64_step.sv
// combinational codec step: one item against the group state gives up to two results
module cab64_step (
   input  logic                 direction,
   input  logic [1:0]           phase,
   input  logic [7:0]           held,
   input  cab64_pkg::req_type   item,
   output cab64_pkg::step_type  step
);

   logic [7:0] d;
   logic       last;
   logic [6:0] v;
   logic [7:0] v8;

   assign d = item.data_in;
   assign last = item.last_in;
   assign v = cab64_pkg::dec_value(d);
   assign v8 = {1'b0, v};

   // one item through encoder or decoder
   always_comb begin
      step = '0;
      if (direction == cab64_pkg::DirEncode) begin
         case (phase)
            2'd1: begin
               step.res0.data_out = cab64_pkg::enc_char({held[1:0], d[7:4]});
               step.res1.data_out = cab64_pkg::enc_char({d[3:0], 2'b00});
               step.res1.last_out = 1'b1;
               step.count = last ? 2'd2 : 2'd1;
               step.held = d;
               step.phase = 2'd2;
            end
            2'd2: begin
               step.res0.data_out = cab64_pkg::enc_char({held[3:0], d[7:6]});
               step.res1.data_out = cab64_pkg::enc_char(d[5:0] & cab64_pkg::SextetMask);
               step.res1.last_out = last;
               step.count = 2'd2;
               step.held = 8'd0;
               step.phase = 2'd0;
            end
            default: begin
               // phase zero, and the unused phase three
               step.res0.data_out = cab64_pkg::enc_char(d[7:2]);
               step.res1.data_out =
                  cab64_pkg::enc_char(6'((8'(d << 4)) & cab64_pkg::HighPairMask));
               step.res1.last_out = 1'b1;
               step.count = last ? 2'd2 : 2'd1;
               step.held = d;
               step.phase = 2'd1;
            end
         endcase
      end else begin
         step.held = v8;
         step.res0.last_out = last;
         case (phase)
            2'd0: begin
               step.count = 2'd0;
               step.phase = 2'd1;
            end
            2'd1: begin
               step.res0.data_out = 8'(held << 2) | (v8 >> 4);
               step.count = 2'd1;
               step.phase = 2'd2;
            end
            2'd2: begin
               step.res0.data_out = 8'(held << 4) | (v8 >> 2);
               step.count = 2'd1;
               step.phase = 2'd3;
            end
            default: begin
               step.res0.data_out = 8'(held << 6) | v8;
               step.count = 2'd1;
               step.phase = 2'd0;
            end
         endcase
      end
      // end of message clears the group
      if (last) begin
         step.phase = 2'd0;
         step.held = 8'd0;
      end
   end

endmodule

// File: bench/custom_alphabet_base64_codec_top_test.sv
// testbench for the custom-alphabet base64 codec: directed and random streams, checked item by item
`timescale 1ns / 1ps

module custom_alphabet_base64_codec_top_test;

   localparam int TableLen = 92;
   localparam logic [6:0] NullCharPos = 7'd94;
   localparam logic [8*TableLen-1:0] CharTable =
      "OPUV01234wxyzABCD9abcdeJKLMNWXYZ `~!@#f5678ghijklmnopquvEFGHIQRST$%^&*()_+-=[]\\{}|;':\",./<>?";
   localparam int RandomItems = 650;
   localparam int SettleCycles = 10;
   localparam int TimeoutNs = 2_000_000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   cab64_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   cab64_pkg::rsp_type rsp_data;
   logic               csr_wr_en = 1'b0;
   logic               csr_wr_data = 1'b0;

   // codec state as the bench tracks it
   logic       model_dir = cab64_pkg::DirEncode;
   logic [1:0] model_phase = 2'd0;
   logic [7:0] model_held = 8'd0;

   cab64_pkg::rsp_type expected_outputs[$];
   cab64_pkg::rsp_type oldest_output;

   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int messages_sent = 0;
   int direction_writes = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int cycle_count = 0;

   custom_alphabet_base64_codec_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // sextet to alphabet character
   function automatic logic [7:0] sextet_char(input logic [5:0] six);
      return CharTable[8*(TableLen - 1 - int'(six)) +: 8];
   endfunction

   // character to its table position, first match wins
   function automatic logic [6:0] char_position(input logic [7:0] c);
      if (c == 8'd0) begin
         return NullCharPos;
      end
      for (int i = 0; i < TableLen; i++) begin
         if (CharTable[8*(TableLen - 1 - i) +: 8] == c) begin
            return 7'(i);
         end
      end
      return 7'd0;
   endfunction

   function automatic void push_output(input logic [7:0] d, input logic l);
      cab64_pkg::rsp_type r;
      r.data_out = d;
      r.last_out = l;
      expected_outputs.push_back(r);
   endfunction

   // work out the results of one accepted item and advance the tracked state
   function automatic void predict_codec_outputs(input cab64_pkg::req_type item);
      logic [7:0] d;
      logic       l;
      logic [1:0] ph;
      logic [6:0] pos;
      logic [7:0] b;
      d = item.data_in;
      l = item.last_in;
      ph = model_phase;
      if (model_dir == cab64_pkg::DirEncode) begin
         if (ph == 2'd3) begin
            ph = 2'd0;
         end
         case (ph)
            2'd0: begin
               push_output(sextet_char(d[7:2]), 1'b0);
               if (l) push_output(sextet_char({d[1:0], 4'b0000}), 1'b1);
               model_held = d;
               model_phase = 2'd1;
            end
            2'd1: begin
               push_output(sextet_char({model_held[1:0], d[7:4]}), 1'b0);
               if (l) push_output(sextet_char({d[3:0], 2'b00}), 1'b1);
               model_held = d;
               model_phase = 2'd2;
            end
            default: begin
               push_output(sextet_char({model_held[3:0], d[7:6]}), 1'b0);
               push_output(sextet_char(d[5:0]), l);
               model_held = 8'd0;
               model_phase = 2'd0;
            end
         endcase
      end else begin
         pos = char_position(d);
         case (ph)
            2'd0: begin
               model_phase = 2'd1;
            end
            2'd1: begin
               b = (model_held << 2) | (pos >> 4);
               push_output(b, l);
               model_phase = 2'd2;
            end
            2'd2: begin
               b = (model_held << 4) | (pos >> 2);
               push_output(b, l);
               model_phase = 2'd3;
            end
            default: begin
               b = (model_held << 6) | pos;
               push_output(b, l);
               model_phase = 2'd0;
            end
         endcase
         model_held = {1'b0, pos};
      end
      if (l) begin
         model_phase = 2'd0;
         model_held = 8'd0;
      end
   endfunction

   // receiver stall pattern: modes drawn at random, each held for a random run
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 120);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 9) < 6);
         default: rsp_stall <= (cycle_count[2:0] >= 3'd5);
      endcase
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            $error("unexpected result: data_out=%h last_out=%b",
                   rsp_data.data_out, rsp_data.last_out);
            error_count++;
         end else begin
            oldest_output = expected_outputs.pop_front();
            results_checked++;
            if (rsp_data.data_out !== oldest_output.data_out) begin
               $error("data_out mismatch: expected %h, got %h",
                      oldest_output.data_out, rsp_data.data_out);
               error_count++;
            end
            if (rsp_data.last_out !== oldest_output.last_out) begin
               $error("last_out mismatch: expected %b, got %b",
                      oldest_output.last_out, rsp_data.last_out);
               error_count++;
            end
         end
      end
   end

   // send one item, with bursts and random gaps in between
   task automatic send_item(input logic [7:0] d, input logic l);
      cab64_pkg::req_type item;
      int gap;
      item.data_in = d;
      item.last_in = l;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      predict_codec_outputs(item);
      items_sent++;
      if (l) messages_sent++;
   endtask

   // hold off the sender until every expected result has come, then settle
   task automatic drain_outputs();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_direction(input logic dir);
      drain_outputs();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= dir;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      model_dir = dir;
      model_phase = 2'd0;
      model_held = 8'd0;
      direction_writes++;
   endtask

   // first character in the top byte of the used part
   task automatic send_chars(input logic [63:0] chars, input int len, input logic with_last);
      for (int i = 0; i < len; i++) begin
         send_item(chars[8*(len - 1 - i) +: 8], with_last && (i == len - 1));
      end
   endtask

   task automatic send_random_message(input int len, input logic with_last);
      logic [7:0] d;
      int pick;
      for (int i = 0; i < len; i++) begin
         if (model_dir == cab64_pkg::DirEncode) begin
            d = 8'($urandom_range(0, 255));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 85) d = CharTable[8*(TableLen - 1 - $urandom_range(0, TableLen - 1)) +: 8];
            else if (pick < 92) d = 8'd0;
            else d = 8'($urandom_range(0, 255));
         end
         send_item(d, with_last && (i == len - 1));
      end
   endtask

   // encode tails of one and two bytes, a full group, extreme bytes
   task automatic test_encode_directed();
      send_chars(64'hFF, 1, 1'b1);
      send_chars(64'h00FF, 2, 1'b1);
      send_chars(64'hA55AC3FF, 4, 1'b1);
   endtask

   // decode: null and foreign bytes, highest position, tails of three, two and one
   task automatic test_decode_directed();
      write_direction(cab64_pkg::DirDecode);
      send_chars({"O?", 8'h00, "~", 8'hFF, "z"}, 6, 1'b1);
      send_chars("???", 3, 1'b1);
      send_chars(64'h00, 1, 1'b1);
   endtask

   // direction written while a group is only partly filled
   task automatic test_direction_midmessage();
      write_direction(cab64_pkg::DirEncode);
      send_chars(64'h8001, 2, 1'b0);
      write_direction(cab64_pkg::DirDecode);
      send_chars("OP", 2, 1'b1);
      send_chars("?z~", 3, 1'b0);
      write_direction(cab64_pkg::DirEncode);
      send_chars(64'h7E, 1, 1'b1);
   endtask

   // random phases, each with its own direction; some messages cut short
   task automatic test_random_streams();
      int sent;
      int phase_items;
      int phase_end;
      int len;
      logic dir;
      sent = 0;
      dir = cab64_pkg::DirEncode;
      while (sent < RandomItems) begin
         dir = ($urandom_range(0, 2) == 0) ? dir : ~dir;
         write_direction(dir);
         phase_items = $urandom_range(60, 140);
         phase_end = sent + phase_items;
         while (sent < phase_end && sent < RandomItems) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
            send_random_message(len, 1'b1);
            sent += len;
            if ($urandom_range(0, 9) == 0) drain_outputs();
         end
         if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 3);
            send_random_message(len, 1'b0);
            sent += len;
         end
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_encode_directed();
      test_decode_directed();
      test_direction_midmessage();
      test_random_streams();
      drain_outputs();
      $display("covered %0d items in %0d complete messages, %0d results checked",
               items_sent, messages_sent, results_checked);
      $display("both directions, %0d direction writes, %s",
               direction_writes, "tails of every length, null and foreign characters");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TimeoutNs);
      $display("timeout with %0d results outstanding", expected_outputs.size());
      $display("Some tests failed");
      $finish;
   end

endmodule

// File: custom_alphabet_base64_codec_top.f
rtl/cab64_pkg.sv
rtl/cab64_step.sv
rtl/custom_alphabet_base64_codec_top.sv
bench/custom_alphabet_base64_codec_top_test.sv
